### rtl/core/tjt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tjt_pkg
// Shared types, codes and keyword tables for the typed JSON text tokenizer.
// ----------------------------------------------------------------------------
package tjt_pkg;

    // Field widths, fixed by the result format
    localparam int POS_W    = 20;
    localparam int LEN_W    = 21;
    localparam int KIND_W   = 5;
    localparam int MAXTOK_W = 16;
    localparam int TCNT_W   = 17;

    // Results one character can cause
    localparam int MAX_RES  = 3;

    // Keyword table
    localparam int KW_COUNT = 9;

    // Lexer mode
    typedef enum logic [1:0] {
        LEX_IDLE    = 2'd0,
        LEX_BARE    = 2'd1,
        LEX_QUOTE   = 2'd2,
        LEX_KEYWORD = 2'd3
    } t_lex_mode;

    // Result codes
    typedef enum logic [1:0] {
        RC_TOKEN   = 2'd0,
        RC_DONE    = 2'd1,
        RC_BAD     = 2'd2,
        RC_NOSPACE = 2'd3
    } t_result_code;

    // Token kinds after the keywords; KIND_NONE reuses code 0
    localparam logic [KIND_W-1:0] KIND_NONE     = 5'd0;
    localparam logic [KIND_W-1:0] KIND_LBRACE   = 5'd9;
    localparam logic [KIND_W-1:0] KIND_RBRACE   = 5'd10;
    localparam logic [KIND_W-1:0] KIND_LBRACKET = 5'd11;
    localparam logic [KIND_W-1:0] KIND_RBRACKET = 5'd12;
    localparam logic [KIND_W-1:0] KIND_COMMA    = 5'd13;
    localparam logic [KIND_W-1:0] KIND_COLON    = 5'd14;
    localparam logic [KIND_W-1:0] KIND_STRING   = 5'd15;
    localparam logic [KIND_W-1:0] KIND_INTEGER  = 5'd16;

    // Keyword text, right aligned: byte 0 of a keyword sits highest
    localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
        72'("(int32)"), 72'("(uint32)"), 72'("(int64)"), 72'("(uint64)"),
        72'("(str)"), 72'("(raw)"), 72'("(rawfile)"), 72'("(array)"),
        72'("(object)")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd8, 4'd7, 4'd8, 4'd5, 4'd5, 4'd9, 4'd7, 4'd8
    };

    // One result item
    typedef struct packed {
        t_result_code      code;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  errpos;
        logic              last;
    } t_result;

    // All results of one character
    typedef struct packed {
        logic [1:0]                cnt;
        t_result [MAX_RES-1:0]     res;
    } t_bundle;

    // Queue status toward the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Byte i of keyword k; zero past its end
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] i);
        logic [71:0] s;
        logic [3:0]  l;
        logic [3:0]  j;
        s = KW_TEXT[k];
        l = KW_LEN[k];
        j = l - 4'd1 - i;
        if (i >= l) begin
            return 8'd0;
        end
        return s[{j, 3'b000} +: 8];
    endfunction

    function automatic t_result mk_res(
        input t_result_code      code,
        input logic [KIND_W-1:0] kind,
        input logic [POS_W-1:0]  start,
        input logic [LEN_W-1:0]  length,
        input logic [LEN_W-1:0]  errpos,
        input logic              last
    );
        t_result r;
        r.code   = code;
        r.kind   = kind;
        r.start  = start;
        r.length = length;
        r.errpos = errpos;
        r.last   = last;
        return r;
    endfunction

endpackage

### rtl/core/tjt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tjt_queue
// Small flop queue of result bundles between the lexer front and the
// result back end.
// ----------------------------------------------------------------------------
module tjt_queue
    import tjt_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_bundle   i_wdata,
    input  logic      i_pop,
    output t_bundle   o_rdata,
    output t_q_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;
    logic            full;
    logic            empty;
    logic            do_push;
    logic            do_pop;

    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;

    assign o_status.full  = full;
    assign o_status.empty = empty;
    assign o_rdata        = r_mem[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

### rtl/core/tjt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tjt_front
// Lexer front: takes one character a cycle unless the queue is full,
// tracks the token in progress and builds the bundle each character causes.
// ----------------------------------------------------------------------------
module tjt_front
    import tjt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_text_valid,
    output logic                o_text_ready,
    input  logic [7:0]          i_text_char,
    input  logic                i_text_last,
    input  logic                i_cfg_we,
    input  logic [MAXTOK_W-1:0] i_cfg_wdata,
    input  t_q_status           i_q_status,
    output logic                o_push,
    output t_bundle             o_bundle
);

    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;
    localparam logic [7:0] CH_LBRACK = 8'd91;
    localparam logic [7:0] CH_RBRACK = 8'd93;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_COLON  = 8'd58;

    // Lexer state
    logic [MAXTOK_W-1:0] r_max_tokens;
    t_lex_mode           r_mode,   n_mode;
    logic [POS_W-1:0]    r_pos,    n_pos;
    logic [POS_W-1:0]    r_tbeg,   n_tbeg;
    logic                r_alldig, n_alldig;
    logic                r_bsodd,  n_bsodd;
    logic [KW_COUNT-1:0] r_cand,   n_cand;
    logic [3:0]          r_kidx,   n_kidx;
    logic [TCNT_W-1:0]   r_tcnt,   n_tcnt;
    logic                r_discard, n_discard;

    // Character class
    logic [7:0]        c;
    logic              is_ws, is_dig, is_par, is_quo, is_bsl;
    logic              pk_vld;
    logic [KIND_W-1:0] pk_kind;

    // Keyword match
    logic [KW_COUNT-1:0] cand_n;
    logic                hit_v;
    logic [3:0]          hit_k;

    // Decisions for this character
    logic              accept;
    logic              term;
    logic              a_val, a_kw, a_bad, a_emit, a_nosp, ok_a;
    logic              start_idle, b_act, b_emit, b_nosp, ok_b;
    logic              c_act, c_emit, c_bad, c_nosp, ok_fin, c_done;
    logic [TCNT_W-1:0] max_ext, cnt_b, cnt_c;
    t_lex_mode         mode_ab;
    logic [POS_W-1:0]  tbeg_ab;
    logic              alldig_ab, bsodd_ab;
    logic [KW_COUNT-1:0] cand_ab;
    logic [3:0]        kidx_ab;
    logic [POS_W-1:0]  dist_a, dist_c;
    logic [1:0]        n_res;
    t_bundle           bnd;

    assign c            = i_text_char;
    assign o_text_ready = !i_q_status.full;
    assign accept       = i_text_valid && o_text_ready;

    // Character classes
    always_comb begin
        is_ws  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        is_par = (c == CH_LPAREN);
        is_quo = (c == CH_QUOTE);
        is_bsl = (c == CH_BSLASH);
        pk_vld = 1'b1;
        unique case (c)
            CH_LBRACE: pk_kind = KIND_LBRACE;
            CH_RBRACE: pk_kind = KIND_RBRACE;
            CH_LBRACK: pk_kind = KIND_LBRACKET;
            CH_RBRACK: pk_kind = KIND_RBRACKET;
            CH_COMMA:  pk_kind = KIND_COMMA;
            CH_COLON:  pk_kind = KIND_COLON;
            default: begin
                pk_kind = KIND_NONE;
                pk_vld  = 1'b0;
            end
        endcase
    end

    // Keyword candidates, one compare per keyword
    always_comb begin
        cand_n = r_cand;
        hit_v  = 1'b0;
        hit_k  = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (r_cand[k]) begin
                if (r_kidx >= KW_LEN[k] || kw_char(4'(k), r_kidx) != c) begin
                    cand_n[k] = 1'b0;
                end else if (r_kidx + 4'd1 == KW_LEN[k]) begin
                    hit_v = 1'b1;
                    hit_k = 4'(k);
                end
            end
        end
    end

    // Classify: ending a token, starting one, closing the text
    always_comb begin
        max_ext = {1'b0, r_max_tokens};
        term    = is_ws || pk_vld || is_par;

        // Token in progress
        a_val  = (r_mode == LEX_BARE && term) ||
                 (r_mode == LEX_QUOTE && is_quo && !r_bsodd);
        a_kw   = (r_mode == LEX_KEYWORD) && (cand_n != '0) && hit_v;
        a_bad  = (r_mode == LEX_KEYWORD) && (cand_n == '0);
        a_emit = a_val || a_kw;
        a_nosp = a_emit && (r_tcnt >= max_ext);
        ok_a   = !a_bad && !a_nosp;

        // New token starting on this character
        start_idle = (r_mode == LEX_IDLE) || (r_mode == LEX_BARE && term && ok_a);
        b_act      = ok_a && start_idle && !is_ws;
        b_emit     = b_act && pk_vld;
        cnt_b      = r_tcnt + TCNT_W'(a_emit);
        b_nosp     = b_emit && (cnt_b >= max_ext);
        ok_b       = ok_a && !b_nosp;

        // State after the first two steps
        mode_ab   = a_emit ? LEX_IDLE : r_mode;
        tbeg_ab   = r_tbeg;
        alldig_ab = r_alldig;
        bsodd_ab  = r_bsodd;
        cand_ab   = (r_mode == LEX_KEYWORD) ? cand_n : r_cand;
        kidx_ab   = (r_mode == LEX_KEYWORD && !a_bad && !a_kw) ? r_kidx + 4'd1 : r_kidx;
        if (r_mode == LEX_BARE && !term) begin
            alldig_ab = r_alldig && is_dig;
        end
        if (r_mode == LEX_QUOTE && !a_val) begin
            alldig_ab = r_alldig && is_dig;
            bsodd_ab  = is_bsl ? !r_bsodd : 1'b0;
        end
        if (b_act && !pk_vld) begin
            tbeg_ab = r_pos;
            if (is_par) begin
                mode_ab = LEX_KEYWORD;
                cand_ab = '1;
                kidx_ab = 4'd1;
            end else if (is_quo) begin
                mode_ab   = LEX_QUOTE;
                alldig_ab = 1'b1;
                bsodd_ab  = 1'b0;
            end else begin
                mode_ab   = LEX_BARE;
                alldig_ab = is_dig;
            end
        end

        // End of the text
        c_act  = ok_b && i_text_last;
        c_emit = c_act && (mode_ab == LEX_BARE);
        c_bad  = c_act && (mode_ab == LEX_QUOTE || mode_ab == LEX_KEYWORD);
        cnt_c  = cnt_b + TCNT_W'(b_emit);
        c_nosp = c_emit && (cnt_c >= max_ext);
        ok_fin = ok_b && !c_bad && !c_nosp;
        c_done = i_text_last && ok_fin;

        dist_a = r_pos - r_tbeg;
        dist_c = r_pos - tbeg_ab;
    end

    // Next lexer state
    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_tbeg    = r_tbeg;
        n_alldig  = r_alldig;
        n_bsodd   = r_bsodd;
        n_cand    = r_cand;
        n_kidx    = r_kidx;
        n_tcnt    = r_tcnt;
        n_discard = r_discard;
        if (accept) begin
            if (i_text_last) begin
                n_mode    = LEX_IDLE;
                n_pos     = '0;
                n_tbeg    = '0;
                n_alldig  = 1'b1;
                n_bsodd   = 1'b0;
                n_cand    = '1;
                n_kidx    = '0;
                n_tcnt    = '0;
                n_discard = 1'b0;
            end else if (!r_discard) begin
                if (!ok_fin) begin
                    n_discard = 1'b1;
                end else begin
                    n_mode   = mode_ab;
                    n_pos    = r_pos + 1'b1;
                    n_tbeg   = tbeg_ab;
                    n_alldig = alldig_ab;
                    n_bsodd  = bsodd_ab;
                    n_cand   = cand_ab;
                    n_kidx   = kidx_ab;
                    n_tcnt   = cnt_c;
                end
            end
        end
    end

    // Result bundle, in emission order
    always_comb begin
        bnd   = '0;
        n_res = '0;
        if (a_bad) begin
            bnd.res[n_res] = mk_res(RC_BAD, KIND_NONE, '0, '0,
                                    {1'b0, r_tbeg} + LEN_W'(1), 1'b1);
            n_res = n_res + 2'd1;
        end else if (a_nosp) begin
            bnd.res[n_res] = mk_res(RC_NOSPACE, KIND_NONE, '0, '0, '0, 1'b1);
            n_res = n_res + 2'd1;
        end else if (a_kw) begin
            bnd.res[n_res] = mk_res(RC_TOKEN, {1'b0, hit_k}, r_tbeg, '0, '0, 1'b0);
            n_res = n_res + 2'd1;
        end else if (a_val) begin
            if (r_mode == LEX_QUOTE) begin
                bnd.res[n_res] = mk_res(RC_TOKEN, r_alldig ? KIND_INTEGER : KIND_STRING,
                                        r_tbeg + 1'b1, {1'b0, dist_a} - LEN_W'(1),
                                        '0, 1'b0);
            end else begin
                bnd.res[n_res] = mk_res(RC_TOKEN, r_alldig ? KIND_INTEGER : KIND_STRING,
                                        r_tbeg, {1'b0, dist_a}, '0, 1'b0);
            end
            n_res = n_res + 2'd1;
        end
        if (b_emit) begin
            if (b_nosp) begin
                bnd.res[n_res] = mk_res(RC_NOSPACE, KIND_NONE, '0, '0, '0, 1'b1);
            end else begin
                bnd.res[n_res] = mk_res(RC_TOKEN, pk_kind, r_pos, '0, '0, 1'b0);
            end
            n_res = n_res + 2'd1;
        end
        if (c_bad) begin
            bnd.res[n_res] = mk_res(RC_BAD, KIND_NONE, '0, '0,
                                    {1'b0, tbeg_ab} + LEN_W'(1), 1'b1);
            n_res = n_res + 2'd1;
        end else if (c_emit) begin
            if (c_nosp) begin
                bnd.res[n_res] = mk_res(RC_NOSPACE, KIND_NONE, '0, '0, '0, 1'b1);
            end else begin
                bnd.res[n_res] = mk_res(RC_TOKEN, alldig_ab ? KIND_INTEGER : KIND_STRING,
                                        tbeg_ab, {1'b0, dist_c} + LEN_W'(1), '0, 1'b0);
            end
            n_res = n_res + 2'd1;
        end
        if (c_done) begin
            bnd.res[n_res] = mk_res(RC_DONE, KIND_NONE, '0, '0, '0, 1'b1);
            n_res = n_res + 2'd1;
        end
        bnd.cnt = n_res;
    end

    assign o_bundle = bnd;
    assign o_push   = accept && !r_discard && (n_res != '0);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tokens <= MAXTOK_W'(40960);
            r_mode       <= LEX_IDLE;
            r_pos        <= '0;
            r_tbeg       <= '0;
            r_alldig     <= 1'b1;
            r_bsodd      <= 1'b0;
            r_cand       <= '1;
            r_kidx       <= '0;
            r_tcnt       <= '0;
            r_discard    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_tokens <= i_cfg_wdata;
            end
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_tbeg    <= n_tbeg;
            r_alldig  <= n_alldig;
            r_bsodd   <= n_bsodd;
            r_cand    <= n_cand;
            r_kidx    <= n_kidx;
            r_tcnt    <= n_tcnt;
            r_discard <= n_discard;
        end
    end

endmodule

### rtl/core/tjt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tjt_back
// Result back end: unpacks queued bundles into single result items and
// holds them in the output register until taken.
// ----------------------------------------------------------------------------
module tjt_back
    import tjt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_bundle   i_q_rdata,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_result   o_res
);

    t_bundle    r_bnd,       n_bnd;
    logic       r_bnd_valid, n_bnd_valid;
    logic [1:0] r_idx,       n_idx;
    t_result    r_out,       n_out;
    logic       r_out_valid, n_out_valid;

    logic load_out;
    logic last_of;
    logic take;

    // Unpack control
    always_comb begin
        load_out = r_bnd_valid && (!r_out_valid || i_res_ready);
        last_of  = (r_idx == r_bnd.cnt - 2'd1);
        take     = !r_bnd_valid || (load_out && last_of);
        o_pop    = take && !i_q_status.empty;
    end

    // Next bundle, index and output register
    always_comb begin
        n_bnd       = r_bnd;
        n_bnd_valid = r_bnd_valid;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out       = r_bnd.res[r_idx];
            n_out_valid = 1'b1;
            n_idx       = r_idx + 2'd1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end
        if (take) begin
            n_bnd       = i_q_rdata;
            n_bnd_valid = !i_q_status.empty;
            n_idx       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_bnd_valid <= n_bnd_valid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_bnd <= n_bnd;
        r_out <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

### rtl/core/typed_json_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_json_text_tokenizer_unit
// Tokenizer for typed JSON-like text: punctuation, type keywords, bare and
// quoted values, with offsets, lengths, a token limit and error results.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                    | payload
//  text      | in        | i_text_valid / o_text_ready  | i_text_char, i_text_last
//  result    | out       | o_res_valid / i_res_ready    | o_result_code .. o_run_last
//  config    | in        | i_cfg_we (no wait)           | i_cfg_wdata (max_tokens)
//
//  One character is taken per cycle; each causes zero to three result items.
//  Results leave at one per cycle while i_res_ready is high.
//  The bundle queue (QUEUE_DEPTH entries) lets the lexer run while the
//  output stalls; the input stalls only when the queue is full.
//  Reset is synchronous, active low; max_tokens resets to 40960.
// ----------------------------------------------------------------------------
module typed_json_text_tokenizer_unit
    import tjt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_text_valid,
    output logic                o_text_ready,
    input  logic [7:0]          i_text_char,
    input  logic                i_text_last,
    input  logic                i_cfg_we,
    input  logic [MAXTOK_W-1:0] i_cfg_wdata,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [1:0]          o_result_code,
    output logic [KIND_W-1:0]   o_token_kind,
    output logic [POS_W-1:0]    o_token_start,
    output logic [LEN_W-1:0]    o_token_length,
    output logic [LEN_W-1:0]    o_error_position,
    output logic                o_run_last
);

    t_bundle   push_data;
    t_bundle   pop_data;
    logic      push;
    logic      pop;
    t_q_status q_status;
    t_result   res;

    tjt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_valid (i_text_valid),
        .o_text_ready (o_text_ready),
        .i_text_char  (i_text_char),
        .i_text_last  (i_text_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_bundle     (push_data)
    );

    tjt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (push_data),
        .i_pop    (pop),
        .o_rdata  (pop_data),
        .o_status (q_status)
    );

    tjt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_rdata   (pop_data),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (res)
    );

    assign o_result_code    = res.code;
    assign o_token_kind     = res.kind;
    assign o_token_start    = res.start;
    assign o_token_length   = res.length;
    assign o_error_position = res.errpos;
    assign o_run_last       = res.last;

endmodule
